// File: sv/ilir_pkg.sv
// ----------------------------------------------------------------------------
// ilir_pkg
// Shared types and codes for the indexed list with insert and remove.
// ----------------------------------------------------------------------------
package ilir_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = 5;
    localparam int LEN_W    = 5;
    localparam int WORD_W   = 32;
    localparam int REQ_W    = 3;
    localparam int ST_W     = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_READ   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_WRITE  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_INSERT = 3'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd3;
    localparam logic [REQ_W-1:0] REQ_APPEND = 3'd4;
    localparam logic [REQ_W-1:0] REQ_DROP   = 3'd5;

    // status codes
    localparam logic [ST_W-1:0] ST_DONE  = 2'd0;
    localparam logic [ST_W-1:0] ST_RANGE = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    // controller to datapath commands
    typedef struct packed {
        logic exec;      // apply the accepted request and load the result register
        logic load_cfg;  // empty the list and load the initial length
    } t_cmd;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_value;
        logic        [LEN_W-1:0]  length;
        logic        [ST_W-1:0]   status;
    } t_rsp;

endpackage

// File: sv/ilir_ctrl.sv
// ----------------------------------------------------------------------------
// ilir_ctrl
// Handshake controller: tracks the output register and issues commands.
// ----------------------------------------------------------------------------
module ilir_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  logic            i_cfg_we,
    output ilir_pkg::t_cmd  o_cmd
);

    localparam logic S_EMPTY = 1'b0;
    localparam logic S_HOLD  = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    // take a new request whenever the result register is free or being drained
    assign o_s_tready = (r_state == S_EMPTY) || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == S_HOLD);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_EMPTY: begin
                if (accept) begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (i_m_tready && !accept) begin
                    n_state = S_EMPTY;
                end
            end
            default: n_state = S_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_cmd.exec     = accept;
    assign o_cmd.load_cfg = i_cfg_we;

endmodule

// File: sv/ilir_dpath.sv
// ----------------------------------------------------------------------------
// ilir_dpath
// Row of entry cells with shift up and down, length counter, result register.
// ----------------------------------------------------------------------------
module ilir_dpath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ilir_pkg::t_cmd                       i_cmd,
    input  logic        [ilir_pkg::REQ_W-1:0]    i_req_type,
    input  logic        [ilir_pkg::IDX_W-1:0]    i_index,
    input  logic signed [ilir_pkg::WORD_W-1:0]   i_value,
    input  logic        [ilir_pkg::LEN_W-1:0]    i_cfg_data,
    output ilir_pkg::t_rsp                       o_rsp
);

    logic signed [ilir_pkg::WORD_W-1:0] r_cell [ilir_pkg::CAPACITY];
    logic signed [ilir_pkg::WORD_W-1:0] n_cell [ilir_pkg::CAPACITY];
    logic        [ilir_pkg::LEN_W-1:0]  r_count;
    logic        [ilir_pkg::LEN_W-1:0]  n_count;
    ilir_pkg::t_rsp                     r_rsp;
    ilir_pkg::t_rsp                     n_rsp;

    logic in_list;    // index < length
    logic ins_pos;    // index <= length
    logic full;
    logic do_write;
    logic do_insert;
    logic do_remove;
    logic do_append;
    logic do_drop;
    logic [ilir_pkg::LEN_W-1:0] last;

    assign in_list = ({1'b0, i_index} < {1'b0, r_count});
    assign ins_pos = ({1'b0, i_index} <= {1'b0, r_count});
    assign full    = (r_count >= ilir_pkg::CAP_LEN);
    assign last    = r_count - 1'b1;

    always_comb begin
        do_write  = 1'b0;
        do_insert = 1'b0;
        do_remove = 1'b0;
        do_append = 1'b0;
        do_drop   = 1'b0;
        n_rsp.read_value = '0;
        n_rsp.status     = ilir_pkg::ST_DONE;
        unique case (i_req_type)
            ilir_pkg::REQ_READ: begin
                if (in_list) begin
                    n_rsp.read_value = r_cell[i_index[$clog2(ilir_pkg::CAPACITY)-1:0]];
                end else begin
                    n_rsp.status = ilir_pkg::ST_RANGE;
                end
            end
            ilir_pkg::REQ_WRITE: begin
                if (in_list) begin
                    do_write = 1'b1;
                end else begin
                    n_rsp.status = ilir_pkg::ST_RANGE;
                end
            end
            ilir_pkg::REQ_INSERT: begin
                // a bad index is reported ahead of a full list
                if (!ins_pos) begin
                    n_rsp.status = ilir_pkg::ST_RANGE;
                end else if (full) begin
                    n_rsp.status = ilir_pkg::ST_FULL;
                end else begin
                    do_insert = 1'b1;
                end
            end
            ilir_pkg::REQ_REMOVE: begin
                if (in_list) begin
                    do_remove = 1'b1;
                end else begin
                    n_rsp.status = ilir_pkg::ST_RANGE;
                end
            end
            ilir_pkg::REQ_APPEND: begin
                if (full) begin
                    n_rsp.status = ilir_pkg::ST_FULL;
                end else begin
                    do_append = 1'b1;
                end
            end
            ilir_pkg::REQ_DROP: begin
                if (r_count == '0) begin
                    n_rsp.status = ilir_pkg::ST_RANGE;
                end else begin
                    do_drop = 1'b1;
                end
            end
            default: ;
        endcase

        n_count = r_count;
        if (do_insert || do_append) begin
            n_count = r_count + 1'b1;
        end else if (do_remove || do_drop) begin
            n_count = last;
        end
        n_rsp.length = n_count;
    end

    // each cell picks from itself, its neighbours or the request word
    always_comb begin
        for (int i = 0; i < ilir_pkg::CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
            if (do_write && (i_index == ilir_pkg::IDX_W'(i))) begin
                n_cell[i] = i_value;
            end
            if (do_append && (r_count == ilir_pkg::LEN_W'(i))) begin
                n_cell[i] = i_value;
            end
            if (do_insert) begin
                if (i_index == ilir_pkg::IDX_W'(i)) begin
                    n_cell[i] = i_value;
                end else if (i > 0 && (i_index < ilir_pkg::IDX_W'(i))
                             && (ilir_pkg::LEN_W'(i) <= r_count)) begin
                    n_cell[i] = r_cell[(i > 0) ? i - 1 : 0];
                end
            end
            if (do_remove && (i < ilir_pkg::CAPACITY - 1)
                && (i_index <= ilir_pkg::IDX_W'(i))
                && ({1'b0, ilir_pkg::LEN_W'(i)} < {1'b0, last})) begin
                n_cell[i] = r_cell[(i < ilir_pkg::CAPACITY - 1) ? i + 1 : i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.load_cfg) begin
            // saturate an oversized initial length
            r_count <= (i_cfg_data > ilir_pkg::CAP_LEN) ? ilir_pkg::CAP_LEN : i_cfg_data;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ilir_pkg::CAPACITY; i++) begin
            if (i_cmd.load_cfg) begin
                r_cell[i] <= '0;
            end else if (i_cmd.exec) begin
                r_cell[i] <= n_cell[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// File: sv/indexed_list_insert_remove.sv
// ----------------------------------------------------------------------------
// indexed_list_insert_remove
// Ordered list of signed 32-bit words with indexed read, write, insert and
// remove, append and drop last, held in a row of sixteen register cells.
// ----------------------------------------------------------------------------
// Each request transfer on the slave side produces exactly one result
// transfer on the master side, pending in the cycle after acceptance. The row
// of cells shifts up or down by one place as a request executes, and the
// result register sits between the two sides, so a new request is taken in
// every cycle while results are drained: one request per cycle sustained.
// Writing the configuration register empties the list and loads that many
// zero entries (saturating at the capacity); write it only while no result
// is outstanding.
module indexed_list_insert_remove (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [4:0] index, [36:5] value, [39:37] zero
    input  logic [2:0]  s_tuser,   // [2:0] req_type
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] read_value, [36:32] length, [39:37] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    // initial length register
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_data
);

    ilir_pkg::t_cmd cmd;
    ilir_pkg::t_rsp rsp;

    // controller: track the result register and decide each transfer
    ilir_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_cfg_we   (i_cfg_we),
        .o_cmd      (cmd)
    );

    // datapath: unpack the request fields straight from the stream
    ilir_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_req_type (s_tuser),
        .i_index    (s_tdata[4:0]),
        .i_value    (s_tdata[36:5]),
        .i_cfg_data (i_cfg_data),
        .o_rsp      (rsp)
    );

    // pack the result, pad the unused top bits
    assign m_tdata = {3'b000, rsp.length, rsp.read_value};
    assign m_tuser = rsp.status;

    // an accepted request always leaves a result pending in the next cycle
    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted request produced no result");

    // length never passes the capacity
    a_length_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> (m_tdata[36:32] <= ilir_pkg::CAP_LEN))
        else $error("length above capacity");

    // a full flag only ever comes with a full list
    a_full_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tuser == ilir_pkg::ST_FULL)) |-> (m_tdata[36:32] == ilir_pkg::CAP_LEN))
        else $error("full status with list not full");

    // a read word only accompanies a successful request
    a_read_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && (m_tdata[31:0] != 32'd0)) |-> (m_tuser == ilir_pkg::ST_DONE))
        else $error("read word on a failed request");

endmodule
